@@ hdl/ple_pkg.sv @@
// package for the positional list engine
// holds command and status codes, the cell control struct and fixed field widths
// no dependencies
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 9;
    localparam int LEN_W  = 9;
    localparam int CMD_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_PRIOR  = 3'd3,
        CMD_NEXT   = 3'd4,
        CMD_CLEAR  = 3'd5
    } command_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_POS   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ROTATE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } state_t;

endpackage

@@ hdl/ple_cell.sv @@
// one list entry of the positional list engine
// takes its neighbor's word on insert, delete and rotate; uses ple_pkg
module ple_cell #(
    parameter int IW  = 8,
    parameter int IDX = 0
) (
    input  logic                          aclk,
    input  ple_pkg::cell_ctrl_t           ctrl,
    input  logic [IW-1:0]                 at_idx,
    input  logic [IW-1:0]                 last_idx,
    input  logic [ple_pkg::DATA_W-1:0]    head_data,
    input  logic [ple_pkg::DATA_W-1:0]    left_data,
    input  logic [ple_pkg::DATA_W-1:0]    right_data,
    output logic [ple_pkg::DATA_W-1:0]    data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [ple_pkg::DATA_W-1:0] data_reg;
    logic [ple_pkg::DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            ple_pkg::CELL_ROTATE: begin
                if (MY_IDX == last_idx) begin
                    data_next = head_data;
                end else if (MY_IDX < last_idx) begin
                    data_next = right_data;
                end
            end
            ple_pkg::CELL_INSERT: begin
                if (MY_IDX == at_idx) begin
                    data_next = ctrl.value;
                end else if (MY_IDX > at_idx) begin
                    data_next = left_data;
                end
            end
            ple_pkg::CELL_DELETE: begin
                if (MY_IDX >= at_idx) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/ple_row.sv @@
// row of list cells, each wired to its two neighbors
// instantiates ple_cell; uses ple_pkg
module ple_row #(
    parameter int CAPACITY = 256,
    parameter int IW       = 8
) (
    input  logic                          aclk,
    input  ple_pkg::cell_ctrl_t           ctrl,
    input  logic [IW-1:0]                 at_idx,
    input  logic [IW-1:0]                 last_idx,
    output logic [ple_pkg::DATA_W-1:0]    head_data,
    output logic [ple_pkg::DATA_W-1:0]    second_data
);

    logic [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [ple_pkg::DATA_W-1:0] left_w;
        logic [ple_pkg::DATA_W-1:0] right_w;

        if (gi == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[gi+1];
        end

        ple_cell #(
            .IW  (IW),
            .IDX (gi)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .at_idx     (at_idx),
            .last_idx   (last_idx),
            .head_data  (cell_data[0]),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[gi])
        );
    end

    assign head_data   = cell_data[0];
    assign second_data = cell_data[1];

endmodule

@@ hdl/positional_list_engine.sv @@
// Fixed-capacity ordered list of signed words held in a row of cells, one entry per cell.
// Insert, clear and unused codes load their result straight from the busy state; get,
// delete, prior and next first make one full rotation of the occupied cells past the head
// pair, where the position or value compare is made, and then load theirs. An insert or
// delete moves every later cell by one, all cells in the same cycle. A new item
// is taken whenever the engine is idle, even while the previous result still waits in the
// output register; a finished item whose result cannot be loaded yet holds the engine in
// its last cycle until the waiting result is taken.
// top level; instantiates ple_row and uses ple_pkg
module positional_list_engine #(
    parameter int CAPACITY = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // position[8:0], value_in[40:9], zero fill
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // value_out[31:0], list_length[40:32], is_empty[41], zero fill
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int DW = ple_pkg::DATA_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

    ple_pkg::state_t                state_reg, state_next;
    logic [ple_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [ple_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [DW-1:0]                  val_reg, val_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  step_reg, step_next;
    logic                           found_reg, found_next;
    logic [DW-1:0]                  result_reg, result_next;
    logic                           m_valid_reg, m_valid_next;
    ple_pkg::status_t               out_status_reg, out_status_next;
    logic [DW-1:0]                  out_value_reg, out_value_next;
    logic [ple_pkg::LEN_W-1:0]      out_len_reg, out_len_next;
    logic                           out_empty_reg, out_empty_next;

    ple_pkg::cell_ctrl_t            cell_ctrl;
    logic [DW-1:0]                  head_data;
    logic [DW-1:0]                  second_data;
    logic [IW-1:0]                  at_idx;
    logic [IW-1:0]                  last_idx;

    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic [PW-1:0]                  step_plus;
    logic [PW-1:0]                  pos_minus;
    logic [PW-1:0]                  cnt_minus;
    logic                           scan_cmd;

    assign pos_ext   = PW'(pos_reg);
    assign cnt_ext   = PW'(count_reg);
    assign step_plus = PW'(step_reg) + PW'(1);
    assign pos_minus = pos_ext - PW'(1);
    assign cnt_minus = cnt_ext - PW'(1);
    assign at_idx    = pos_minus[IW-1:0];
    assign last_idx  = cnt_minus[IW-1:0];
    assign scan_cmd  = cmd_reg inside {ple_pkg::CMD_DELETE, ple_pkg::CMD_GET,
                                       ple_pkg::CMD_PRIOR, ple_pkg::CMD_NEXT};

    ple_row #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_row (
        .aclk        (aclk),
        .ctrl        (cell_ctrl),
        .at_idx      (at_idx),
        .last_idx    (last_idx),
        .head_data   (head_data),
        .second_data (second_data)
    );

    always_comb begin
        ple_pkg::status_t stat_v;
        logic [CW-1:0]    count_v;

        stat_v          = ple_pkg::STAT_OK;
        count_v         = count_reg;
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        result_next     = result_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_len_next    = out_len_reg;
        out_empty_next  = out_empty_reg;
        cell_ctrl.op    = ple_pkg::CELL_HOLD;
        cell_ctrl.value = val_reg;
        s_tready        = (state_reg == ple_pkg::S_IDLE);

        case (state_reg)
            ple_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_tuser;
                    pos_next    = s_tdata[8:0];
                    val_next    = s_tdata[40:9];
                    step_next   = '0;
                    found_next  = 1'b0;
                    result_next = '0;
                    state_next  = ple_pkg::S_BUSY;
                end
            end
            ple_pkg::S_BUSY: begin
                if (scan_cmd && (step_reg < count_reg)) begin
                    // rotate: head holds element step, second holds element step+1
                    cell_ctrl.op = ple_pkg::CELL_ROTATE;
                    step_next    = step_reg + CW'(1);
                    case (cmd_reg)
                        ple_pkg::CMD_GET, ple_pkg::CMD_DELETE: begin
                            if (step_plus == pos_ext) begin
                                result_next = head_data;
                            end
                        end
                        ple_pkg::CMD_PRIOR: begin
                            if (!found_reg && (step_plus < cnt_ext) && (second_data == val_reg)) begin
                                found_next  = 1'b1;
                                result_next = head_data;
                            end
                        end
                        ple_pkg::CMD_NEXT: begin
                            if (!found_reg && (step_plus < cnt_ext) && (head_data == val_reg)) begin
                                found_next  = 1'b1;
                                result_next = second_data;
                            end
                        end
                        default: begin
                            result_next = result_reg;
                        end
                    endcase
                end else if (!m_valid_reg || m_tready) begin
                    case (cmd_reg)
                        ple_pkg::CMD_INSERT: begin
                            if ((pos_ext == '0) || (pos_ext > cnt_ext + PW'(1))) begin
                                stat_v = ple_pkg::STAT_BAD_POS;
                            end else if (cnt_ext >= PW'(CAPACITY)) begin
                                stat_v = ple_pkg::STAT_FULL;
                            end else begin
                                cell_ctrl.op = ple_pkg::CELL_INSERT;
                                count_v      = count_reg + CW'(1);
                            end
                        end
                        ple_pkg::CMD_DELETE: begin
                            if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                                stat_v = ple_pkg::STAT_BAD_POS;
                            end else begin
                                cell_ctrl.op = ple_pkg::CELL_DELETE;
                                count_v      = count_reg - CW'(1);
                            end
                        end
                        ple_pkg::CMD_GET: begin
                            if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                                stat_v = ple_pkg::STAT_BAD_POS;
                            end
                        end
                        ple_pkg::CMD_PRIOR, ple_pkg::CMD_NEXT: begin
                            stat_v = found_reg ? ple_pkg::STAT_OK : ple_pkg::STAT_NOT_FOUND;
                        end
                        ple_pkg::CMD_CLEAR: begin
                            count_v = '0;
                        end
                        default: begin
                            stat_v = ple_pkg::STAT_OK;
                        end
                    endcase
                    count_next      = count_v;
                    out_status_next = stat_v;
                    out_value_next  = result_reg;
                    out_len_next    = ple_pkg::LEN_W'(count_v);
                    out_empty_next  = (count_v == '0);
                    m_valid_next    = 1'b1;
                    state_next      = ple_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ple_pkg::S_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        result_reg     <= result_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_len_reg    <= out_len_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'b0, out_empty_reg, out_len_reg, out_value_reg};

endmodule
